// ===== src/spb_pkg.sv =====
// ----------------------------------------------------------------------------
// spb_pkg - shared types and constants of the parallel bus to SPI master bridge
// Holds the bus command codes, config byte layout, speed decode and the
// result record that the engine hands to the output stage.
// ----------------------------------------------------------------------------
package spb_pkg;

  // bus command codes; the fourth code acts as a clock tick only
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_RSVD  = 2'd3
  } spb_cmd_t;

  // register select
  localparam logic REG_DATA   = 1'b0;
  localparam logic REG_CONFIG = 1'b1;

  // config byte layout
  localparam int CFG_CS_LO  = 0;
  localparam int CFG_CS_HI  = 1;
  localparam int CFG_LSB    = 2;
  localparam int CFG_CPOL   = 3;
  localparam int CFG_CPHA   = 4;
  localparam int CFG_SPD_LO = 5;
  localparam int CFG_SPD_HI = 6;
  localparam int CFG_DBL    = 7;

  localparam int DIV_W  = 7;
  localparam int BITS_W = 4;

  localparam logic [7:0]        DATA_RESET   = 8'hff;
  localparam logic [BITS_W-1:0] BITS_PER_XFR = 4'd8;
  localparam logic [2:0]        SEL_NONE     = 3'b111;

  // half SPI period in system clocks for a speed code and double-speed bit
  function automatic logic [DIV_W-1:0] half_period(input logic [1:0] spd,
                                                   input logic dbl);
    logic [DIV_W-1:0] h;
    case (spd)
      2'd0:    h = 7'd2;
      2'd1:    h = 7'd8;
      2'd2:    h = 7'd32;
      2'd3:    h = 7'd64;
      default: h = 7'd2;
    endcase
    return dbl ? (h >> 1) : h;
  endfunction

  // one result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [2:0] select_n;
    logic       in_use_n;
    logic       sck;
    logic       mosi;
    logic       busy;
  } spb_result_t;

endpackage

// ===== src/spb_engine.sv =====
// ----------------------------------------------------------------------------
// spb_engine - bridge register file and SPI shift engine
// Holds config, data and shift state; advances it by one system tick per
// accepted beat and forms that beat's result from the updated state.
// ----------------------------------------------------------------------------
module spb_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [1:0]           command,
  input  logic                 reg_select,
  input  logic [7:0]           write_value,
  input  logic                 miso,
  output spb_pkg::spb_result_t result
);

  logic [7:0]                  config_r, config_nxt;
  logic [7:0]                  data_r, data_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic [spb_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [spb_pkg::DIV_W-1:0]   div_r, div_nxt;
  logic                        level_r, level_nxt;
  logic                        active_r, active_nxt;

  always_comb begin
    logic [spb_pkg::DIV_W-1:0] half;
    logic [spb_pkg::DIV_W-1:0] div_inc;
    logic                      do_shift;
    logic [1:0]                cs;
    logic [7:0]                rdata;
    logic                      irq;

    config_nxt = config_r;
    data_nxt   = data_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    div_nxt    = div_r;
    level_nxt  = level_r;
    active_nxt = active_r;
    rdata      = 8'd0;
    irq        = 1'b0;
    do_shift   = 1'b0;
    half       = spb_pkg::half_period(config_r[spb_pkg::CFG_SPD_HI:spb_pkg::CFG_SPD_LO],
                                      config_r[spb_pkg::CFG_DBL]);
    div_inc    = div_r + 1'b1;

    if (active_r) begin
      if (div_inc < half) begin
        div_nxt = div_inc;
      end else begin
        div_nxt   = '0;
        level_nxt = ~level_r;
        // leading edge samples when CPHA is clear, trailing edge otherwise
        do_shift  = level_nxt ? ~config_r[spb_pkg::CFG_CPHA] : config_r[spb_pkg::CFG_CPHA];
      end
    end

    if (do_shift) begin
      if (config_r[spb_pkg::CFG_LSB]) shift_nxt = {miso, shift_r[7:1]};
      else                            shift_nxt = {shift_r[6:0], miso};
      if (bits_r != '0) bits_nxt = bits_r - 1'b1;
    end

    if (active_r) begin
      // trailing edge after the last bit closes the transfer
      if (div_inc >= half && !level_nxt && bits_nxt == '0) begin
        data_nxt   = shift_nxt;
        active_nxt = 1'b0;
        irq        = 1'b1;
      end
    end else if (command == spb_pkg::CMD_READ) begin
      rdata = (reg_select == spb_pkg::REG_CONFIG) ? config_r : data_r;
      irq   = 1'b1;
    end else if (command == spb_pkg::CMD_WRITE) begin
      if (reg_select == spb_pkg::REG_CONFIG) begin
        config_nxt = write_value;
        irq        = 1'b1;
      end else begin
        shift_nxt  = write_value;
        bits_nxt   = spb_pkg::BITS_PER_XFR;
        div_nxt    = '0;
        level_nxt  = 1'b0;
        active_nxt = 1'b1;
      end
    end

    cs = config_nxt[spb_pkg::CFG_CS_HI:spb_pkg::CFG_CS_LO];
    case (cs)
      2'd0:    result.select_n = spb_pkg::SEL_NONE;
      2'd1:    result.select_n = 3'b110;
      2'd2:    result.select_n = 3'b101;
      2'd3:    result.select_n = 3'b011;
      default: result.select_n = spb_pkg::SEL_NONE;
    endcase
    result.read_data = rdata;
    result.irq       = irq;
    result.in_use_n  = (cs == 2'd0);
    result.sck       = config_nxt[spb_pkg::CFG_CPOL] ^ level_nxt;
    result.mosi      = config_nxt[spb_pkg::CFG_LSB] ? shift_nxt[0] : shift_nxt[7];
    result.busy      = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      config_r <= '0;
      data_r   <= spb_pkg::DATA_RESET;
      shift_r  <= '0;
      bits_r   <= '0;
      div_r    <= '0;
      level_r  <= 1'b0;
      active_r <= 1'b0;
    end else if (step) begin
      config_r <= config_nxt;
      data_r   <= data_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      div_r    <= div_nxt;
      level_r  <= level_nxt;
      active_r <= active_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= spb_pkg::BITS_PER_XFR)
    else $error("spb_engine: bit count above one byte");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (div_r == '0 && !level_r))
    else $error("spb_engine: divider or clock level left over while idle");

  a_end_after_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> ($past(bits_r) <= 4'd1 && !level_r))
    else $error("spb_engine: transfer ended before its last bit");
`endif

endmodule

// ===== src/parallel_bus_spi_master_bridge.sv =====
// Latency: a beat's result is registered at the edge that accepts it and is
//   offered on the out_ channel from the next cycle.
// Throughput: one beat per cycle; in_ready stays high while the result register
//   is empty or being drained in the same cycle (the result register alone paces it).
// Reset: synchronous, active low; clears config, shift state and the result
//   valid flag, and sets the data register to all ones.
// ----------------------------------------------------------------------------
// parallel_bus_spi_master_bridge - parallel bus to SPI master bridge
// Each accepted beat is one system clock tick carrying an optional bus
// access; the engine updates its state and the result lands in an output
// register that parts the input side from the result side.
// ----------------------------------------------------------------------------
module parallel_bus_spi_master_bridge (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic       in_reg_select,
  input  logic [7:0] in_write_value,
  input  logic       in_miso,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic [2:0] out_select_n,
  output logic       out_in_use_n,
  output logic       out_sck,
  output logic       out_mosi,
  output logic       out_busy_res
);

  logic                 out_valid_r;
  spb_pkg::spb_result_t res_r;
  spb_pkg::spb_result_t res_nxt;
  logic                 accept;

  // take a new beat whenever the result register frees up this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  spb_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .command     (in_command),
    .reg_select  (in_reg_select),
    .write_value (in_write_value),
    .miso        (in_miso),
    .result      (res_nxt)
  );

  // result valid flag: set on accept, drop when drained with nothing new
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = res_r.read_data;
  assign out_irq       = res_r.irq;
  assign out_select_n  = res_r.select_n;
  assign out_in_use_n  = res_r.in_use_n;
  assign out_sck       = res_r.sck;
  assign out_mosi      = res_r.mosi;
  assign out_busy_res  = res_r.busy;

`ifndef ASSERT_OFF
  a_read_needs_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_read_data != 8'd0) |-> out_irq)
    else $error("bridge: read data offered without completion pulse");

  a_select_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_in_use_n == (out_select_n == spb_pkg::SEL_NONE)))
    else $error("bridge: in-use flag disagrees with select lines");
`endif

endmodule

// ===== tb/tb_parallel_bus_spi_master_bridge.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_parallel_bus_spi_master_bridge - bench for the parallel bus to SPI bridge
// Feeds system clock ticks with optional bus reads and writes, predicts every
// result beat from a cycle model of the register file and the SPI shifter,
// and checks each beat on the result channel under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_parallel_bus_spi_master_bridge;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 13;
  localparam int RANDOM_BEATS = 60;
  localparam int SLOW_TICKS   = 140;
  localparam int REPORT_MAX   = 10;

  typedef enum int {MISO_LOW, MISO_HIGH, MISO_RAND} miso_pattern_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  spb_pkg::spb_cmd_t in_command;
  logic              in_reg_select;
  logic [7:0]        in_write_value;
  logic              in_miso;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_read_data;
  logic              out_irq;
  logic [2:0]        out_select_n;
  logic              out_in_use_n;
  logic              out_sck;
  logic              out_mosi;
  logic              out_busy_res;

  // Bridge state as the bench sees it; starts at its reset value.
  logic [7:0]                 bridge_cfg  = '0;
  logic [7:0]                 bridge_data = spb_pkg::DATA_RESET;
  logic [7:0]                 shreg       = '0;
  logic [spb_pkg::BITS_W-1:0] bits_rem    = '0;
  logic [spb_pkg::DIV_W-1:0]  div_cnt     = '0;
  logic                       clk_lvl     = 1'b0;
  logic                       xfer_on     = 1'b0;

  spb_pkg::spb_result_t spi_beats_due[$];

  int  err_count    = 0;
  int  cycle_count  = 0;
  int  beats_sent   = 0;
  bit  in_gaps_on   = 1'b1;
  bit  out_stall_on = 1'b1;

  parallel_bus_spi_master_bridge uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_reg_select (in_reg_select),
    .in_write_value(in_write_value),
    .in_miso       (in_miso),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_irq       (out_irq),
    .out_select_n  (out_select_n),
    .out_in_use_n  (out_in_use_n),
    .out_sck       (out_sck),
    .out_mosi      (out_mosi),
    .out_busy_res  (out_busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bail out if the run hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("parallel_bus_spi_master_bridge test failed");
      $finish;
    end
  end

  // Half SPI period in system ticks for a config byte.
  function automatic logic [spb_pkg::DIV_W-1:0] spi_half(input logic [7:0] c);
    logic [spb_pkg::DIV_W-1:0] h;
    case (c[spb_pkg::CFG_SPD_HI:spb_pkg::CFG_SPD_LO])
      2'd0: h = 7'd2;
      2'd1: h = 7'd8;
      2'd2: h = 7'd32;
      default: h = 7'd64;
    endcase
    if (c[spb_pkg::CFG_DBL]) h = h >> 1;
    return h;
  endfunction

  function automatic logic [7:0] spi_cfg(input logic [1:0] cs, input logic lsb,
                                         input logic cpol, input logic cpha,
                                         input logic [1:0] spd, input logic dbl);
    logic [7:0] c;
    c = '0;
    c[spb_pkg::CFG_CS_HI:spb_pkg::CFG_CS_LO]   = cs;
    c[spb_pkg::CFG_LSB]                        = lsb;
    c[spb_pkg::CFG_CPOL]                       = cpol;
    c[spb_pkg::CFG_CPHA]                       = cpha;
    c[spb_pkg::CFG_SPD_HI:spb_pkg::CFG_SPD_LO] = spd;
    c[spb_pkg::CFG_DBL]                        = dbl;
    return c;
  endfunction

  // Advance the bridge by one tick and queue the beat it must produce.
  task automatic predict_spi_tick(input spb_pkg::spb_cmd_t cmd, input logic rs,
                                  input logic [7:0] val, input logic miso);
    spb_pkg::spb_result_t r;
    logic [1:0]           cs;
    logic                 take;
    r = '0;
    if (xfer_on) begin
      // Bus accesses are ignored here; only the divider and the shifter run.
      div_cnt = div_cnt + 1'b1;
      if (div_cnt >= spi_half(bridge_cfg)) begin
        div_cnt = '0;
        clk_lvl = ~clk_lvl;
        // Sample on the leading edge for CPHA 0, on the trailing edge for CPHA 1.
        take = clk_lvl ? !bridge_cfg[spb_pkg::CFG_CPHA] : bridge_cfg[spb_pkg::CFG_CPHA];
        if (take) begin
          shreg = bridge_cfg[spb_pkg::CFG_LSB] ? {miso, shreg[7:1]} : {shreg[6:0], miso};
          if (bits_rem != '0) bits_rem = bits_rem - 1'b1;
        end
        // Eighth trailing edge: latch the received byte and finish.
        if (!clk_lvl && bits_rem == '0) begin
          bridge_data = shreg;
          xfer_on     = 1'b0;
          r.irq       = 1'b1;
        end
      end
    end else if (cmd == spb_pkg::CMD_READ) begin
      r.read_data = (rs == spb_pkg::REG_CONFIG) ? bridge_cfg : bridge_data;
      r.irq       = 1'b1;
    end else if (cmd == spb_pkg::CMD_WRITE) begin
      if (rs == spb_pkg::REG_CONFIG) begin
        bridge_cfg = val;
        r.irq      = 1'b1;
      end else begin
        shreg    = val;
        bits_rem = spb_pkg::BITS_PER_XFR;
        div_cnt  = '0;
        clk_lvl  = 1'b0;
        xfer_on  = 1'b1;
      end
    end
    cs = bridge_cfg[spb_pkg::CFG_CS_HI:spb_pkg::CFG_CS_LO];
    r.select_n = (cs == 2'd0) ? spb_pkg::SEL_NONE
                              : (spb_pkg::SEL_NONE & ~(3'b001 << (cs - 2'd1)));
    r.in_use_n = (cs == 2'd0);
    r.sck      = bridge_cfg[spb_pkg::CFG_CPOL] ^ clk_lvl;
    r.mosi     = bridge_cfg[spb_pkg::CFG_LSB] ? shreg[0] : shreg[7];
    r.busy     = xfer_on;
    spi_beats_due.push_back(r);
  endtask

  // Predict on every accepted input beat; sampled before the edge takes effect.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_spi_tick(in_command, in_reg_select, in_write_value, in_miso);
  end

  // Check every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    spb_pkg::spb_result_t got;
    spb_pkg::spb_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{read_data: out_read_data, irq: out_irq, select_n: out_select_n,
              in_use_n: out_in_use_n, sck: out_sck, mosi: out_mosi,
              busy: out_busy_res};
      if (spi_beats_due.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < REPORT_MAX)
          $display("cycle %0d: result beat with nothing pending: %p", cycle_count, got);
      end else begin
        exp_r = spi_beats_due.pop_front();
        if (got.read_data !== exp_r.read_data || got.irq !== exp_r.irq ||
            got.select_n !== exp_r.select_n || got.in_use_n !== exp_r.in_use_n ||
            got.sck !== exp_r.sck || got.mosi !== exp_r.mosi ||
            got.busy !== exp_r.busy) begin
          err_count <= err_count + 1;
          if (err_count < REPORT_MAX)
            $display("cycle %0d: mismatch expected %p got %p",
                     cycle_count, exp_r, got);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before taking each beat.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_stall_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Send one tick; entered and left at a falling edge.
  task automatic send_beat(input spb_pkg::spb_cmd_t cmd, input logic rs,
                           input logic [7:0] val, input logic miso);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_reg_select  <= rs;
    in_write_value <= val;
    in_miso        <= miso;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Pick a plain tick, or now and then a random bus access.
  function automatic spb_pkg::spb_cmd_t noisy_cmd(input int noise_pct);
    if ($urandom_range(0, 99) < noise_pct)
      return spb_pkg::spb_cmd_t'($urandom_range(0, 3));
    return spb_pkg::CMD_TICK;
  endfunction

  // Keep ticking until the running byte is done; mix in accesses the
  // bridge must drop while busy.
  task automatic clock_out_bits(input miso_pattern_t pat, input int noise_pct);
    spb_pkg::spb_cmd_t cmd;
    logic              miso;
    while (xfer_on) begin
      cmd  = noisy_cmd(noise_pct);
      miso = (pat == MISO_LOW) ? 1'b0 : (pat == MISO_HIGH) ? 1'b1 : 1'($urandom);
      send_beat(cmd, 1'($urandom), 8'($urandom), miso);
    end
  endtask

  // Program the config register, then shift one byte through.
  task automatic shift_byte_out(input logic [7:0] cfg, input logic [7:0] val,
                                input miso_pattern_t pat, input int noise_pct);
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_CONFIG, cfg, 1'($urandom));
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_DATA, val, 1'($urandom));
    clock_out_bits(pat, noise_pct);
  endtask

  // Reset values, idle commands, config extremes and every chip select.
  task automatic test_register_access();
    send_beat(spb_pkg::CMD_READ,  spb_pkg::REG_DATA,   8'h00, 1'b0);
    send_beat(spb_pkg::CMD_READ,  spb_pkg::REG_CONFIG, 8'hff, 1'b1);
    send_beat(spb_pkg::CMD_TICK,  spb_pkg::REG_CONFIG, 8'hff, 1'b1);
    send_beat(spb_pkg::CMD_RSVD,  spb_pkg::REG_DATA,   8'hff, 1'b0);
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_CONFIG, 8'hff, 1'b0);
    send_beat(spb_pkg::CMD_READ,  spb_pkg::REG_CONFIG, 8'h00, 1'b1);
    for (int cs = 1; cs < 4; cs++) begin
      send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_CONFIG,
                spi_cfg(cs[1:0], 1'b0, 1'b0, 1'b0, 2'd0, 1'b0), 1'b0);
      send_beat(spb_pkg::CMD_READ,  spb_pkg::REG_CONFIG, 8'h00, 1'b0);
    end
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_CONFIG, 8'h00, 1'b1);
    send_beat(spb_pkg::CMD_READ,  spb_pkg::REG_DATA,   8'hff, 1'b1);
  endtask

  // Extreme bytes against constant MISO, with busy accesses dropped.
  task automatic test_transfer_extremes();
    shift_byte_out(spi_cfg(2'd1, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1), 8'hff, MISO_LOW, 50);
    send_beat(spb_pkg::CMD_READ, spb_pkg::REG_DATA, 8'h00, 1'b0);
    shift_byte_out(spi_cfg(2'd3, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1), 8'h00, MISO_HIGH, 50);
    send_beat(spb_pkg::CMD_READ, spb_pkg::REG_DATA, 8'hff, 1'b1);
  endtask

  // Every bit order, polarity and phase at speed code 0.
  task automatic test_mode_sweep();
    logic [2:0] m;
    for (int i = 0; i < 8; i++) begin
      m = i[2:0];
      in_gaps_on   = (i % 3) != 0;
      out_stall_on = (i % 2) != 0;
      shift_byte_out(spi_cfg(i[1:0], m[0], m[1], m[2], 2'd0, 1'($urandom)),
                     8'($urandom), MISO_RAND, 10);
      send_beat(spb_pkg::CMD_READ, spb_pkg::REG_DATA, 8'($urandom), 1'($urandom));
    end
  endtask

  // Speed codes 0 and 1 with and without double speed; one full byte each.
  task automatic test_speed_sweep();
    for (int s = 0; s < 2; s++) begin
      for (int d = 0; d < 2; d++) begin
        in_gaps_on   = (d == 0);
        out_stall_on = 1'b1;
        shift_byte_out(spi_cfg(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                               s[1:0], d[0]), 8'($urandom), MISO_RAND, 5);
        send_beat(spb_pkg::CMD_READ, spb_pkg::REG_DATA, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Mostly well-formed config/transfer/read-back sequences, some stray beats.
  task automatic test_random_traffic();
    int                start;
    logic [7:0]        c;
    spb_pkg::spb_cmd_t cmd;
    logic              rs;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      in_gaps_on   = $urandom_range(0, 3) != 0;
      out_stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) < 7) begin
        c = 8'($urandom);
        c[spb_pkg::CFG_SPD_HI] = 1'b0;  // hold to the faster speeds here
        shift_byte_out(c, 8'($urandom), MISO_RAND, $urandom_range(0, 30));
        if ($urandom_range(0, 1) == 1)
          send_beat(spb_pkg::CMD_READ, 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        cmd = spb_pkg::spb_cmd_t'($urandom_range(0, 3));
        rs  = 1'($urandom);
        c   = 8'($urandom);
        if (cmd == spb_pkg::CMD_WRITE && rs == spb_pkg::REG_CONFIG)
          c[spb_pkg::CFG_SPD_HI] = 1'b0;
        send_beat(cmd, rs, c, 1'($urandom));
        clock_out_bits(MISO_RAND, 40);
      end
    end
  endtask

  // Slow speed codes: start one byte and follow the divider through its first
  // clock edges; the byte is left running at the end of the run.
  task automatic test_slow_divider();
    logic [7:0] c;
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    c = spi_cfg(2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                2'($urandom_range(2, 3)), 1'($urandom));
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_CONFIG, c, 1'($urandom));
    send_beat(spb_pkg::CMD_WRITE, spb_pkg::REG_DATA, 8'($urandom), 1'($urandom));
    repeat (SLOW_TICKS)
      send_beat(noisy_cmd(10), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    // Drive every input known from time zero; hold reset low, then release it.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = spb_pkg::CMD_TICK;
    in_reg_select  = spb_pkg::REG_DATA;
    in_write_value = '0;
    in_miso        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_transfer_extremes();
    test_mode_sweep();
    test_speed_sweep();
    test_random_traffic();
    test_slow_divider();

    // Drain: stop sending, wait for every predicted beat, then a short tail
    // to catch stray extra beats.
    in_valid <= 1'b0;
    while (spi_beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0)
      $display("parallel_bus_spi_master_bridge test passed");
    else
      $display("parallel_bus_spi_master_bridge test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spb_pkg.sv
src/spb_engine.sv
src/parallel_bus_spi_master_bridge.sv
tb/tb_parallel_bus_spi_master_bridge.sv
